### rtl/goertzel_fsk_bit_detector_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-tone bit detector
// Shared property forms, clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GOERTZEL_FSK_BIT_DETECTOR_CORE_ASSERT_SVH
`define GOERTZEL_FSK_BIT_DETECTOR_CORE_ASSERT_SVH

// same-cycle implication
`define GFSK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GFSK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/gfsk_pkg.sv
// ----------------------------------------------------------------------------
// gfsk_pkg
// Constants, register indexes and inter-module structs of the bit detector.
// ----------------------------------------------------------------------------
package gfsk_pkg;

  localparam int WIN_LEN = 64;
  localparam int WIN_AW  = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
  localparam int FILL_W  = $clog2(WIN_LEN + 1);

  localparam int QDEPTH  = 2;
  localparam int QAW     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 16;

  localparam logic [8:0]  HOP_RST = 9'd20;
  localparam logic [15:0] THR_RST = 16'd32768;

  localparam logic signed [45:0] ST_MAX = 46'sd549755813887;
  localparam logic signed [45:0] ST_MIN = -46'sd549755813888;

  typedef enum logic [CFG_AW-1:0] {
    REG_MARK_COS  = 3'd0,
    REG_MARK_SIN  = 3'd1,
    REG_SPACE_COS = 3'd2,
    REG_SPACE_SIN = 3'd3,
    REG_HOP_LEN   = 3'd4,
    REG_THRESHOLD = 3'd5
  } gfsk_reg_t;

  typedef struct packed {
    logic signed [15:0] mark_cos;
    logic signed [15:0] mark_sin;
    logic signed [15:0] space_cos;
    logic signed [15:0] space_sin;
    logic [8:0]         hop_length;
    logic [15:0]        threshold;
  } gfsk_cfg_t;

  typedef struct packed {
    logic               clear;
    logic               step;
    logic               fin;
    logic signed [15:0] x;
  } gfsk_tone_cmd_t;

  typedef struct packed {
    logic        done;
    logic [44:0] mag;
  } gfsk_tone_sts_t;

endpackage

### rtl/goertzel_fsk_bit_detector_core.sv
// ----------------------------------------------------------------------------
// goertzel_fsk_bit_detector_core
// Two-tone Goertzel bit detector: front takes samples, back evaluates.
// ----------------------------------------------------------------------------
// A sample that causes no evaluation is taken whenever the input is not stalled.
// For an evaluating sample the back end reads and steps each window sample, then forms
// magnitude and square root (with 0 to 13 normalising shifts) and the division; the next
// sample can be taken in the cycle after the word loads.
// Input is stalled while an evaluation is queued, running or its word waits to load.
// Reset sets only control state and config; the window stays undefined until written.
module goertzel_fsk_bit_detector_core import gfsk_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_audio_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_mark_share,
  output logic               out_decided_bit,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_AW-1:0]  cfg_index,
  input  logic [CFG_DW-1:0]  cfg_data
);

  gfsk_cfg_t          cfg;
  logic               push, pop, q_empty, back_busy;
  logic [WIN_AW-1:0]  push_base, q_base, rd_addr;
  logic signed [15:0] rd_data;

  gfsk_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_audio_sample(in_audio_sample),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cfg(cfg),
    .hold(!q_empty || back_busy),
    .push(push), .push_base(push_base),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  gfsk_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_base(push_base),
    .pop(pop), .head_base(q_base), .empty(q_empty)
  );

  gfsk_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg),
    .q_empty(q_empty), .q_base(q_base), .q_pop(pop), .busy(back_busy),
    .rd_addr(rd_addr), .rd_data(rd_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_mark_share(out_mark_share), .out_decided_bit(out_decided_bit)
  );

endmodule

### rtl/gfsk_queue.sv
// ----------------------------------------------------------------------------
// gfsk_queue
// Short queue of evaluation jobs (oldest window position) between front and back.
// ----------------------------------------------------------------------------
module gfsk_queue import gfsk_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [WIN_AW-1:0] push_base,
  input  logic              pop,
  output logic [WIN_AW-1:0] head_base,
  output logic              empty
);

  logic [WIN_AW-1:0] ent_r [QDEPTH];
  logic [QAW-1:0]    wp_r, rp_r;
  logic [QAW:0]      cnt_r, cnt_nxt;

  assign empty     = (cnt_r == '0);
  assign head_base = ent_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + (QAW+1)'(1);
    else if (pop && !push) cnt_nxt = cnt_r - (QAW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= wp_r + QAW'(1);
      if (pop)  rp_r <= rp_r + QAW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_base;
  end

endmodule

### rtl/gfsk_front.sv
// ----------------------------------------------------------------------------
// gfsk_front
// Config registers, sample window memory, fill/hop counting, job issue.
// ----------------------------------------------------------------------------
module gfsk_front import gfsk_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_audio_sample,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_AW-1:0]  cfg_index,
  input  logic [CFG_DW-1:0]  cfg_data,
  output gfsk_cfg_t          cfg,
  input  logic               hold,
  output logic               push,
  output logic [WIN_AW-1:0]  push_base,
  input  logic [WIN_AW-1:0]  rd_addr,
  output logic signed [15:0] rd_data
);

  gfsk_cfg_t         cfg_r;
  logic [15:0]       win_mem [WIN_LEN];
  logic [15:0]       rd_data_r;
  logic [FILL_W-1:0] fill_r;
  logic [8:0]        hop_r, hop_inc;
  logic [WIN_AW-1:0] wr_pos_r, wr_pos_nxt;
  logic              acc, full;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;
  assign in_stall  = hold;
  assign acc       = in_valid && !in_stall;
  assign full      = (fill_r == FILL_W'(WIN_LEN));
  assign hop_inc   = hop_r + 9'd1;
  assign wr_pos_nxt = (wr_pos_r == WIN_AW'(WIN_LEN - 1)) ? '0 : wr_pos_r + WIN_AW'(1);
  assign push      = acc && full && (hop_inc >= cfg_r.hop_length);
  assign push_base = wr_pos_nxt;
  assign rd_data   = $signed(rd_data_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mark_cos   <= '0;
      cfg_r.mark_sin   <= '0;
      cfg_r.space_cos  <= '0;
      cfg_r.space_sin  <= '0;
      cfg_r.hop_length <= HOP_RST;
      cfg_r.threshold  <= THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MARK_COS:  cfg_r.mark_cos   <= $signed(cfg_data);
        REG_MARK_SIN:  cfg_r.mark_sin   <= $signed(cfg_data);
        REG_SPACE_COS: cfg_r.space_cos  <= $signed(cfg_data);
        REG_SPACE_SIN: cfg_r.space_sin  <= $signed(cfg_data);
        REG_HOP_LEN:   cfg_r.hop_length <= cfg_data[8:0];
        REG_THRESHOLD: cfg_r.threshold  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      hop_r    <= '0;
      wr_pos_r <= '0;
    end else if (acc) begin
      wr_pos_r <= wr_pos_nxt;
      if (!full) begin
        fill_r <= fill_r + FILL_W'(1);
      end else if (push) begin
        hop_r <= '0;
      end else begin
        hop_r <= hop_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) win_mem[wr_pos_r] <= in_audio_sample;
    rd_data_r <= win_mem[rd_addr];
  end

endmodule

### rtl/gfsk_tone.sv
// ----------------------------------------------------------------------------
// gfsk_tone
// One Goertzel recurrence with 40-bit saturated state, then magnitude
// (normalise, square, bit-serial square root).
// ----------------------------------------------------------------------------
module gfsk_tone import gfsk_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [15:0] coef_cos,
  input  logic signed [15:0] coef_sin,
  input  gfsk_tone_cmd_t     cmd,
  output gfsk_tone_sts_t     sts
);

  typedef enum logic [9:0] {
    T_RUN  = 10'b0000000001,
    T_F1   = 10'b0000000010,
    T_F2   = 10'b0000000100,
    T_F3   = 10'b0000001000,
    T_NORM = 10'b0000010000,
    T_SQA  = 10'b0000100000,
    T_SQB  = 10'b0001000000,
    T_SUM  = 10'b0010000000,
    T_ROOT = 10'b0100000000,
    T_DONE = 10'b1000000000
  } tone_st_t;

  tone_st_t           st_r, st_nxt;
  logic               upd_r;
  logic signed [39:0] s1_r, s2_r;
  logic signed [15:0] x_r, coef_sel;
  logic signed [36:0] plo_r, phi_r, plo_m, phi_m;
  logic signed [56:0] full;
  logic signed [56:0] full_p, full_r;
  logic signed [45:0] s_sum;
  logic signed [43:0] re_v, im_v;
  logic [43:0]        a_r, b_r;
  logic [3:0]         k_r;
  logic [30:0]        sq_op;
  logic [61:0]        sq_m, sqa_r, sqb_r;
  logic [63:0]        v_r, res_r, bit_r, trial;
  logic               over;

  assign coef_sel = (st_r == T_F2) ? coef_sin : coef_cos;
  assign plo_m    = 37'(coef_sel) * 37'($signed({1'b0, s1_r[19:0]}));
  assign phi_m    = 37'(coef_sel) * 37'($signed(s1_r[39:20]));
  assign full     = (57'(phi_r) <<< 20) + 57'(plo_r);

  assign full_p = full + 57'sd4096;
  assign full_r = full + 57'sd8192;

  assign s_sum = 46'(x_r) + 46'($signed(full_p[56:13])) - 46'(s2_r);

  assign re_v  = 44'($signed(full_r[56:14])) - 44'(s2_r);
  assign im_v  = 44'($signed(full_r[56:14]));
  assign over  = (|a_r[43:31]) || (|b_r[43:31]);
  assign sq_op = (st_r == T_SQA) ? a_r[30:0] : b_r[30:0];
  assign sq_m  = 62'(sq_op) * 62'(sq_op);
  assign trial = res_r + bit_r;

  assign sts.done = (st_r == T_DONE);
  assign sts.mag  = 45'(res_r) << k_r;

  always_comb begin
    st_nxt = st_r;
    if (cmd.clear) begin
      st_nxt = T_RUN;
    end else begin
      unique case (st_r)
        T_RUN:  if (cmd.fin) st_nxt = T_F1;
        T_F1:   st_nxt = T_F2;
        T_F2:   st_nxt = T_F3;
        T_F3:   st_nxt = T_NORM;
        T_NORM: if (!over) st_nxt = T_SQA;
        T_SQA:  st_nxt = T_SQB;
        T_SQB:  st_nxt = T_SUM;
        T_SUM:  st_nxt = T_ROOT;
        T_ROOT: if (bit_r[0]) st_nxt = T_DONE;
        T_DONE: st_nxt = T_DONE;
        default: st_nxt = T_RUN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= T_RUN;
      upd_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      upd_r <= cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    plo_r <= plo_m;
    phi_r <= phi_m;
    if (cmd.step) x_r <= cmd.x;
    if (cmd.clear) begin
      s1_r <= '0;
      s2_r <= '0;
    end else if (upd_r) begin
      s2_r <= s1_r;
      if (s_sum > ST_MAX)      s1_r <= ST_MAX[39:0];
      else if (s_sum < ST_MIN) s1_r <= ST_MIN[39:0];
      else                     s1_r <= s_sum[39:0];
    end
    unique case (st_r)
      T_F2: begin
        a_r <= re_v[43] ? 44'(-re_v) : 44'(re_v);
        k_r <= '0;
      end
      T_F3: b_r <= im_v[43] ? 44'(-im_v) : 44'(im_v);
      T_NORM: if (over) begin
        a_r <= a_r >> 1;
        b_r <= b_r >> 1;
        k_r <= k_r + 4'd1;
      end
      T_SQA: sqa_r <= sq_m;
      T_SQB: sqb_r <= sq_m;
      T_SUM: begin
        v_r   <= 64'(sqa_r) + 64'(sqb_r);
        res_r <= '0;
        bit_r <= 64'd1 << 62;
      end
      T_ROOT: begin
        if (v_r >= trial) begin
          v_r   <= v_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      default: ;
    endcase
  end

endmodule

### rtl/gfsk_back.sv
// ----------------------------------------------------------------------------
// gfsk_back
// Evaluation sequencer: walks the window through both tone units, forms
// the mark share by restoring division and holds the result word.
// ----------------------------------------------------------------------------
`include "goertzel_fsk_bit_detector_core_assert.svh"

module gfsk_back import gfsk_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  gfsk_cfg_t          cfg,
  input  logic               q_empty,
  input  logic [WIN_AW-1:0]  q_base,
  output logic               q_pop,
  output logic               busy,
  output logic [WIN_AW-1:0]  rd_addr,
  input  logic signed [15:0] rd_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_mark_share,
  output logic               out_decided_bit
);

  typedef enum logic [7:0] {
    B_IDLE = 8'b00000001,
    B_RD   = 8'b00000010,
    B_STEP = 8'b00000100,
    B_GAP  = 8'b00001000,
    B_FIN  = 8'b00010000,
    B_WAIT = 8'b00100000,
    B_DIV  = 8'b01000000,
    B_OUT  = 8'b10000000
  } back_st_t;

  back_st_t          st_r, st_nxt;
  logic [WIN_AW-1:0] addr_r, cnt_r;
  logic [4:0]        dcnt_r;
  logic [46:0]       rem_r, sum_r, tdiv;
  logic [16:0]       q_r;
  logic              out_valid_r, out_load, last;
  logic [15:0]       prob_r, prob;
  logic              bit_r;
  logic [45:0]       sum_w;
  gfsk_tone_cmd_t    cmd;
  gfsk_tone_sts_t    m_sts, s_sts;

  gfsk_tone u_mark (
    .clk(clk), .rst_n(rst_n), .coef_cos(cfg.mark_cos), .coef_sin(cfg.mark_sin),
    .cmd(cmd), .sts(m_sts)
  );

  gfsk_tone u_space (
    .clk(clk), .rst_n(rst_n), .coef_cos(cfg.space_cos), .coef_sin(cfg.space_sin),
    .cmd(cmd), .sts(s_sts)
  );

  assign busy      = (st_r != B_IDLE);
  assign q_pop     = (st_r == B_IDLE) && !q_empty;
  assign rd_addr   = addr_r;
  assign last      = (cnt_r == WIN_AW'(WIN_LEN - 1));
  assign cmd.clear = q_pop;
  assign cmd.step  = (st_r == B_STEP);
  assign cmd.fin   = (st_r == B_FIN);
  assign cmd.x     = rd_data;
  assign sum_w     = 46'(m_sts.mag) + 46'(s_sts.mag);
  assign tdiv      = (dcnt_r == '0) ? rem_r : (rem_r << 1);
  assign prob      = q_r[16] ? 16'hFFFF : q_r[15:0];
  assign out_load  = (st_r == B_OUT) && (!out_valid_r || !out_stall);

  assign out_valid       = out_valid_r;
  assign out_mark_share  = prob_r;
  assign out_decided_bit = bit_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      B_IDLE: if (!q_empty) st_nxt = B_RD;
      B_RD:   st_nxt = B_STEP;
      B_STEP: st_nxt = last ? B_GAP : B_RD;
      B_GAP:  st_nxt = B_FIN;
      B_FIN:  st_nxt = B_WAIT;
      B_WAIT: if (m_sts.done && s_sts.done) st_nxt = (sum_w == '0) ? B_OUT : B_DIV;
      B_DIV:  if (dcnt_r == 5'd16) st_nxt = B_OUT;
      B_OUT:  if (out_load) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_load)       out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      B_IDLE: begin
        addr_r <= q_base;
        cnt_r  <= '0;
      end
      B_STEP: begin
        addr_r <= (addr_r == WIN_AW'(WIN_LEN - 1)) ? '0 : addr_r + WIN_AW'(1);
        cnt_r  <= cnt_r + WIN_AW'(1);
      end
      B_WAIT: begin
        rem_r  <= 47'(m_sts.mag);
        sum_r  <= 47'(sum_w);
        q_r    <= '0;
        dcnt_r <= '0;
      end
      B_DIV: begin
        if (tdiv >= sum_r) begin
          rem_r <= tdiv - sum_r;
          q_r   <= {q_r[15:0], 1'b1};
        end else begin
          rem_r <= tdiv;
          q_r   <= {q_r[15:0], 1'b0};
        end
        dcnt_r <= dcnt_r + 5'd1;
      end
      default: ;
    endcase
    if (out_load) begin
      prob_r <= prob;
      bit_r  <= (prob > cfg.threshold);
    end
  end

  `GFSK_ASSERT_IMP(a_pop_idle, q_pop, st_r == B_IDLE, "job taken while evaluating")
  `GFSK_ASSERT_IMP(a_div_nz, st_r == B_DIV, sum_r != '0, "division by zero sum")
  `GFSK_ASSERT_IMP(a_q_range, st_r == B_OUT, q_r <= 17'd65536, "quotient out of range")
  `GFSK_ASSERT_NXT(a_step_gap, st_r == B_STEP, st_r == B_RD || st_r == B_GAP,
                   "tone steps too close")

endmodule
